// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, when true, implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/msble_pkg.sv -----
// ----------------------------------------------------------------------------
// msble_pkg
// Types and codes shared by the slot list engine modules.
// ----------------------------------------------------------------------------
package msble_pkg;

	// Width of fill counts and capacities.
	localparam int CNT_W = 5;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_APPEND = 3'd1,
		OP_DROP   = 3'd2,
		OP_DELETE = 3'd3,
		OP_READ   = 3'd4,
		OP_SORT   = 3'd5,
		OP_RESIZE = 3'd6,
		OP_COUNT  = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BAD_SLOT    = 4'd1,
		ST_EXISTS      = 4'd2,
		ST_BAD_SIZE    = 4'd3,
		ST_NO_MEMORY   = 4'd4,
		ST_FULL        = 4'd5,
		ST_NO_LIST     = 4'd6,
		ST_EMPTY       = 4'd7,
		ST_NOT_FOUND   = 4'd8,
		ST_BAD_NEWSIZE = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD,
		S_EV,
		S_EMIT
	} fsm_t;

	// One slot table entry.
	typedef struct packed {
		logic             present;
		logic [CNT_W-1:0] cap;
		logic [CNT_W-1:0] fill;
	} slot_ent_t;

	// Write request to the slot table.
	typedef struct packed {
		logic      we;
		slot_ent_t ent;
	} slot_wr_t;

endpackage

// ----- rtl/core/msble_ram.sv -----
// ----------------------------------------------------------------------------
// msble_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module msble_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 160
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/msble_slots.sv -----
// ----------------------------------------------------------------------------
// msble_slots
// Per-slot table of presence, capacity and fill count, cleared by reset.
// ----------------------------------------------------------------------------
module msble_slots #(
	parameter int NUM_SLOTS = 10
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] idx,
	input  msble_pkg::slot_wr_t                            wr,
	output msble_pkg::slot_ent_t                           ent
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	msble_pkg::slot_ent_t tab_q [NUM_SLOTS];
	logic                 in_range;

	assign in_range = ({1'b0, idx} < (SW+1)'(NUM_SLOTS));

	// An index beyond the table reads as an absent slot.
	always_comb begin
		ent = '0;
		if (in_range) begin
			ent = tab_q[idx];
		end
	end

	// Table update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				tab_q[k] <= '0;
			end
		end else if (wr.we && in_range) begin
			tab_q[idx] <= wr.ent;
		end
	end

endmodule

// ----- rtl/core/multi_slot_bounded_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// multi_slot_bounded_list_engine_core
// Bank of numbered slots, each holding a bounded list of signed words in RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tuser: op[2:0]; tdata: slot, amount, operand_value
// m_axis    out  tuser: status[3:0]; tdata: element_value, fill_count; tlast
//
// One item is taken at a time. A simple command is decoded, then answered
// once the output can take it. Delete and plain read handle each filled
// entry as a RAM read, then an evaluate step, bounded by the single RAM read
// port. A sorted read makes n passes, one emit each; n is the fill count.
// Reset clears the slot table at once; the element RAM needs no clearing.
// A stalled output holds the engine in its current step.
// ----------------------------------------------------------------------------
module multi_slot_bounded_list_engine_core #(
	parameter int NUM_SLOTS     = 10,
	parameter int SLOT_CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// slot[3:0], amount[9:4], operand_value[41:10], zero fill
	input  logic [47:0] s_axis_tdata,
	// op[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// element_value[31:0], fill_count[36:32], zero fill
	output logic [39:0] m_axis_tdata,
	// status[3:0]
	output logic [3:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

`include "assert_macros.svh"

	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int DEPTH = NUM_SLOTS * SLOT_CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = msble_pkg::CNT_W;
	localparam logic signed [7:0] CAP_S = 8'(SLOT_CAPACITY);

	msble_pkg::fsm_t      state_q, state_d;
	msble_pkg::op_t       op_q;
	logic [SW-1:0]        slot_idx_q;
	logic                 bad_q;
	logic signed [5:0]    amount_q;
	logic [31:0]          value_q;
	logic [CW-1:0]        i_q, k_q, prev_i_q, best_i_q;
	logic                 found_q, have_prev_q, best_valid_q;
	logic [31:0]          prev_v_q, best_v_q;
	logic                 out_valid_q, out_last_q;
	logic [3:0]           out_status_q;
	logic [31:0]          out_value_q;
	logic [4:0]           out_fill_q;

	msble_pkg::slot_ent_t ent;
	msble_pkg::slot_wr_t  mwr;
	logic                 accept, can_push, push;
	logic [3:0]           o_status;
	logic [31:0]          o_value, rdata, wdata;
	logic [4:0]           o_fill;
	logic                 o_last;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        waddr, raddr, base;
	logic [CW-1:0]        n;
	logic                 go_scan, last_el, found_now, cand, better;
	msble_pkg::status_t   dec_status;
	msble_pkg::slot_ent_t dec_ent;
	logic                 dec_write;
	logic signed [7:0]    newcap, amt_s;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign can_push = !out_valid_q || m_axis_tready;
	assign n        = ent.fill;
	assign base     = AW'(slot_idx_q) * AW'(SLOT_CAPACITY);
	assign last_el  = (i_q == n - CW'(1));

	msble_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (slot_idx_q),
		.wr     (mwr),
		.ent    (ent)
	);

	msble_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Command decode for the single-result commands and the scan start.
	always_comb begin
		amt_s      = 8'(amount_q);
		newcap     = $signed({3'b000, ent.cap}) + amt_s;
		dec_status = msble_pkg::ST_OK;
		dec_ent    = ent;
		dec_write  = 1'b0;
		go_scan    = 1'b0;
		if (bad_q) begin
			dec_status = msble_pkg::ST_BAD_SLOT;
		end else if (op_q == msble_pkg::OP_CREATE) begin
			if (ent.present) begin
				dec_status = msble_pkg::ST_EXISTS;
			end else if (amount_q < 6'sd1) begin
				dec_status = msble_pkg::ST_BAD_SIZE;
			end else if (amt_s > CAP_S) begin
				dec_status = msble_pkg::ST_NO_MEMORY;
			end else begin
				dec_write       = 1'b1;
				dec_ent.present = 1'b1;
				dec_ent.cap     = CW'(amount_q);
				dec_ent.fill    = '0;
			end
		end else if (op_q == msble_pkg::OP_RESIZE) begin
			if (newcap < 8'sd1) begin
				dec_status = msble_pkg::ST_BAD_NEWSIZE;
			end else if (!ent.present) begin
				dec_status = msble_pkg::ST_NO_LIST;
			end else if (newcap > CAP_S) begin
				dec_status = msble_pkg::ST_NO_MEMORY;
			end else begin
				dec_write   = 1'b1;
				dec_ent.cap = CW'(newcap);
				if (ent.fill > CW'(newcap)) begin
					dec_ent.fill = CW'(newcap);
				end
			end
		end else if (!ent.present) begin
			dec_status = msble_pkg::ST_NO_LIST;
		end else begin
			case (op_q)
				msble_pkg::OP_APPEND: begin
					if (n >= ent.cap) begin
						dec_status = msble_pkg::ST_FULL;
					end else begin
						dec_write    = 1'b1;
						dec_ent.fill = n + CW'(1);
					end
				end
				msble_pkg::OP_DROP: begin
					if (n == '0) begin
						dec_status = msble_pkg::ST_EMPTY;
					end else begin
						dec_write    = 1'b1;
						dec_ent.fill = n - CW'(1);
					end
				end
				msble_pkg::OP_DELETE: begin
					if (n == '0) begin
						dec_status = msble_pkg::ST_EMPTY;
					end else begin
						go_scan = 1'b1;
					end
				end
				msble_pkg::OP_READ, msble_pkg::OP_SORT: begin
					go_scan = (n != '0);
				end
				msble_pkg::OP_COUNT: begin
					if (n == '0) begin
						dec_status = msble_pkg::ST_EMPTY;
					end
				end
				default: begin
					dec_status = msble_pkg::ST_OK;
				end
			endcase
		end
	end

	// Scan helpers for delete and sorted read.
	always_comb begin
		found_now = found_q || (rdata == value_q);
		cand      = !have_prev_q || ($signed(rdata) > $signed(prev_v_q)) ||
			((rdata == prev_v_q) && (i_q > prev_i_q));
		better    = cand && (!best_valid_q || ($signed(rdata) < $signed(best_v_q)));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			msble_pkg::S_IDLE: begin
				if (accept) begin
					state_d = msble_pkg::S_DECODE;
				end
			end
			msble_pkg::S_DECODE: begin
				if (go_scan) begin
					state_d = msble_pkg::S_RD;
				end else if (can_push) begin
					state_d = msble_pkg::S_IDLE;
				end
			end
			msble_pkg::S_RD: begin
				state_d = msble_pkg::S_EV;
			end
			msble_pkg::S_EV: begin
				if (op_q == msble_pkg::OP_SORT) begin
					state_d = last_el ? msble_pkg::S_EMIT : msble_pkg::S_RD;
				end else if (op_q == msble_pkg::OP_READ) begin
					if (can_push) begin
						state_d = last_el ? msble_pkg::S_IDLE : msble_pkg::S_RD;
					end
				end else if (!last_el) begin
					state_d = msble_pkg::S_RD;
				end else if (can_push) begin
					state_d = msble_pkg::S_IDLE;
				end
			end
			msble_pkg::S_EMIT: begin
				if (can_push) begin
					state_d = (k_q == n - CW'(1)) ? msble_pkg::S_IDLE : msble_pkg::S_RD;
				end
			end
			default: begin
				state_d = msble_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of each state: result push, table write, RAM access.
	always_comb begin
		push     = 1'b0;
		o_status = msble_pkg::ST_OK;
		o_value  = '0;
		o_fill   = '0;
		o_last   = 1'b1;
		mwr      = '0;
		ram_we   = 1'b0;
		waddr    = base + AW'(i_q) - AW'(1);
		wdata    = rdata;
		ram_re   = 1'b0;
		raddr    = base + AW'(i_q);
		s_axis_tready = (state_q == msble_pkg::S_IDLE);
		case (state_q)
			msble_pkg::S_DECODE: begin
				if (!go_scan) begin
					push     = can_push;
					o_status = dec_status;
					if (op_q == msble_pkg::OP_COUNT && dec_status == msble_pkg::ST_OK) begin
						o_fill = 5'(n);
					end
					mwr.we  = push && dec_write;
					mwr.ent = dec_ent;
					if (op_q == msble_pkg::OP_APPEND) begin
						waddr  = base + AW'(n);
						wdata  = value_q;
						ram_we = push && dec_write;
					end
				end
			end
			msble_pkg::S_RD: begin
				ram_re = 1'b1;
			end
			msble_pkg::S_EV: begin
				if (op_q == msble_pkg::OP_READ) begin
					push    = can_push;
					o_value = rdata;
					o_last  = last_el;
				end else if (op_q == msble_pkg::OP_DELETE) begin
					ram_we = found_q;
					if (last_el) begin
						push     = can_push;
						o_status = found_now ? msble_pkg::ST_OK : msble_pkg::ST_NOT_FOUND;
						mwr.we   = push && found_now;
						mwr.ent  = ent;
						mwr.ent.fill = n - CW'(1);
					end
				end
			end
			msble_pkg::S_EMIT: begin
				push    = can_push;
				o_value = best_v_q;
				o_last  = (k_q == n - CW'(1));
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msble_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command latch and scan registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= msble_pkg::op_t'(s_axis_tuser);
			bad_q      <= (s_axis_tdata[3:0] == 4'd0) ||
				({1'b0, s_axis_tdata[3:0]} > 5'(NUM_SLOTS));
			slot_idx_q <= SW'(s_axis_tdata[3:0] - 4'd1);
			amount_q   <= s_axis_tdata[9:4];
			value_q    <= s_axis_tdata[41:10];
		end
		if (state_q == msble_pkg::S_DECODE) begin
			i_q          <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			have_prev_q  <= 1'b0;
			best_valid_q <= 1'b0;
		end
		if (state_q == msble_pkg::S_EV && state_d != msble_pkg::S_EV) begin
			found_q <= found_now;
			i_q     <= last_el ? '0 : i_q + CW'(1);
			if (op_q == msble_pkg::OP_SORT && better) begin
				best_valid_q <= 1'b1;
				best_v_q     <= rdata;
				best_i_q     <= i_q;
			end
		end
		if (state_q == msble_pkg::S_EMIT && can_push) begin
			prev_v_q     <= best_v_q;
			prev_i_q     <= best_i_q;
			have_prev_q  <= 1'b1;
			best_valid_q <= 1'b0;
			k_q          <= k_q + CW'(1);
			i_q          <= '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= o_status;
			out_value_q  <= o_value;
			out_fill_q   <= o_fill;
			out_last_q   <= o_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {3'b000, out_fill_q, out_value_q};
	assign m_axis_tlast  = out_last_q;

	`ASSERT_ALWAYS(a_fill_within_cap, ent.fill <= ent.cap, "fill count exceeds capacity")
	`ASSERT_NEXT(a_accept_decodes, accept, state_q == msble_pkg::S_DECODE,
		"accepted item not decoded")
	`ASSERT_ALWAYS(a_scan_in_fill, (state_q != msble_pkg::S_EV) || (i_q < ent.fill),
		"scan index beyond filled entries")

endmodule

// ----- tb/sv/list_engine_checker.sv -----
// ----------------------------------------------------------------------------
// list_engine_checker
// Watches both streams of the slot list engine, predicts each command's
// answer items from its own copy of the slot table, and compares them.
// ----------------------------------------------------------------------------
module list_engine_checker
	import msble_pkg::*;
#(
	parameter int NUM_SLOTS     = 10,
	parameter int SLOT_CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [3:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending_answers
);

	typedef struct packed {
		status_t     status;
		logic [31:0] element;
		logic [4:0]  fill;
		logic        last;
	} answer_t;

	answer_t     answer_q[$];
	logic [31:0] words[NUM_SLOTS][SLOT_CAPACITY];
	logic        present[NUM_SLOTS];
	int          fills[NUM_SLOTS];
	int          caps[NUM_SLOTS];

	assign pending_answers = answer_q.size();

	initial begin
		fail_count = 0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			present[k] = 1'b0;
			fills[k] = 0;
			caps[k] = 0;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic void push_answer(status_t st, logic [31:0] el, int fc, logic lst);
		answer_t a;
		a.status = st;
		a.element = el;
		a.fill = fc[4:0];
		a.last = lst;
		answer_q.push_back(a);
	endfunction

	// Apply one command to the shadow slot table and queue its answers.
	task automatic predict_command(input op_t op, input logic [3:0] slot,
			input logic signed [5:0] amount, input logic [31:0] val);
		int          s, n, newcap, hit, j;
		logic [31:0] buf_w[SLOT_CAPACITY];
		logic [31:0] key;
		if (slot < 1 || slot > NUM_SLOTS) begin
			push_answer(ST_BAD_SLOT, 0, 0, 1);
			return;
		end
		s = slot - 1;
		n = fills[s];
		if (op == OP_CREATE) begin
			if (present[s]) push_answer(ST_EXISTS, 0, 0, 1);
			else if (amount < 1) push_answer(ST_BAD_SIZE, 0, 0, 1);
			else if (amount > SLOT_CAPACITY) push_answer(ST_NO_MEMORY, 0, 0, 1);
			else begin
				present[s] = 1'b1;
				caps[s] = amount;
				fills[s] = 0;
				push_answer(ST_OK, 0, 0, 1);
			end
			return;
		end
		if (op == OP_RESIZE) begin
			newcap = caps[s] + amount;
			if (newcap < 1) push_answer(ST_BAD_NEWSIZE, 0, 0, 1);
			else if (!present[s]) push_answer(ST_NO_LIST, 0, 0, 1);
			else if (newcap > SLOT_CAPACITY) push_answer(ST_NO_MEMORY, 0, 0, 1);
			else begin
				caps[s] = newcap;
				if (fills[s] > newcap) fills[s] = newcap;
				push_answer(ST_OK, 0, 0, 1);
			end
			return;
		end
		if (!present[s]) begin
			push_answer(ST_NO_LIST, 0, 0, 1);
			return;
		end
		case (op)
			OP_APPEND: begin
				if (n >= caps[s]) push_answer(ST_FULL, 0, 0, 1);
				else begin
					words[s][n] = val;
					fills[s] = n + 1;
					push_answer(ST_OK, 0, 0, 1);
				end
			end
			OP_DROP: begin
				if (n == 0) push_answer(ST_EMPTY, 0, 0, 1);
				else begin
					fills[s] = n - 1;
					push_answer(ST_OK, 0, 0, 1);
				end
			end
			OP_DELETE: begin
				hit = -1;
				for (int i = 0; i < n; i++)
					if (hit < 0 && words[s][i] == val) hit = i;
				if (n == 0) push_answer(ST_EMPTY, 0, 0, 1);
				else if (hit < 0) push_answer(ST_NOT_FOUND, 0, 0, 1);
				else begin
					for (int i = hit; i + 1 < n; i++) words[s][i] = words[s][i + 1];
					fills[s] = n - 1;
					push_answer(ST_OK, 0, 0, 1);
				end
			end
			OP_READ, OP_SORT: begin
				if (n == 0) push_answer(ST_OK, 0, 0, 1);
				else begin
					for (int i = 0; i < n; i++) buf_w[i] = words[s][i];
					// Insertion sort on signed values for the sorted read.
					if (op == OP_SORT) begin
						for (int i = 1; i < n; i++) begin
							key = buf_w[i];
							j = i;
							while (j > 0 && $signed(buf_w[j - 1]) > $signed(key)) begin
								buf_w[j] = buf_w[j - 1];
								j--;
							end
							buf_w[j] = key;
						end
					end
					for (int i = 0; i < n; i++)
						push_answer(ST_OK, buf_w[i], 0, i + 1 == n);
				end
			end
			default: begin
				if (n == 0) push_answer(ST_EMPTY, 0, 0, 1);
				else push_answer(ST_OK, 0, n, 1);
			end
		endcase
	endtask

	// Predict on input acceptance, compare on output acceptance.
	always @(posedge clk) begin
		answer_t got, exp_a;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.element = m_axis_tdata[31:0];
				got.fill = m_axis_tdata[36:32];
				got.last = m_axis_tlast;
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item status %0d", m_axis_tuser));
				end else begin
					exp_a = answer_q.pop_front();
					if (got.status != exp_a.status)
						report_mismatch($sformatf("status %0d, want %0d",
							got.status, exp_a.status));
					if (got.element != exp_a.element)
						report_mismatch($sformatf("element %0h, want %0h",
							got.element, exp_a.element));
					if (got.fill != exp_a.fill)
						report_mismatch($sformatf("fill %0d, want %0d",
							got.fill, exp_a.fill));
					if (got.last != exp_a.last)
						report_mismatch($sformatf("last %0b, want %0b",
							got.last, exp_a.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_command(op_t'(s_axis_tuser), s_axis_tdata[3:0],
					s_axis_tdata[9:4], s_axis_tdata[41:10]);
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the slot list engine with varied gaps and output
// stalls; the checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_top;
	import msble_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending_answers;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_slot_bounded_list_engine_core dut (.*);

	list_engine_checker chk (.*);

	// Receiver ready, with random stalls and one long hold-off.
	always @(posedge clk) begin
		if (hold_off) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Present one command and hold it until taken; random gaps first.
	// Valid stays high after acceptance until the next command or a gap
	// replaces it, so each edge sees at most one update of valid.
	task automatic send_command(input op_t op, input int slot, input int amount,
			input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, val, amount[5:0], slot[3:0]};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering items and wait until every expected result has come.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_answers != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Mostly commands on valid slots with values from a small pool.
	task automatic send_random(input int count);
		logic [31:0] val;
		int          slot;
		for (int i = 0; i < count; i++) begin
			slot = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 3);
			case ($urandom_range(3))
				0: val = $urandom;
				default: val = {$urandom_range(1) ? 28'hFFFFFFF : 28'h0,
					4'($urandom_range(7))};
			endcase
			send_command(op_t'($urandom_range(7)), slot,
				($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(1, 6), val);
		end
	endtask

	initial begin
		#200000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: bad slots, create limits, full, empty, not found, sort, resize.
		send_command(OP_APPEND, 0, 0, 0);
		send_command(OP_READ, 15, 0, 0);
		send_command(OP_RESIZE, 4, -1, 0);
		send_command(OP_RESIZE, 4, 3, 0);
		send_command(OP_COUNT, 4, 0, 0);
		send_command(OP_CREATE, 1, 0, 0);
		send_command(OP_CREATE, 1, -32, 0);
		send_command(OP_CREATE, 1, 17, 0);
		send_command(OP_CREATE, 1, 3, 0);
		send_command(OP_CREATE, 1, 3, 0);
		send_command(OP_READ, 1, 0, 0);
		send_command(OP_COUNT, 1, 0, 0);
		send_command(OP_DROP, 1, 0, 0);
		send_command(OP_DELETE, 1, 0, 0);
		send_command(OP_APPEND, 1, 0, 32'h7FFFFFFF);
		send_command(OP_APPEND, 1, 0, 32'h80000000);
		send_command(OP_APPEND, 1, 0, 32'hFFFFFFFF);
		send_command(OP_APPEND, 1, 0, 32'h0);
		send_command(OP_SORT, 1, 0, 0);
		send_command(OP_DELETE, 1, 0, 32'h12345678);
		send_command(OP_DELETE, 1, 0, 32'h80000000);
		send_command(OP_RESIZE, 1, 31, 0);
		send_command(OP_RESIZE, 1, -2, 0);
		send_command(OP_CREATE, 10, 16, 0);
		send_command(OP_COUNT, 1, 0, 0);
		// Random phases with varied idling.
		send_random(30);
		wait_drained();
		send_idle_pct = 82;
		send_random(30);
		send_idle_pct = 0;
		recv_stall_pct = 82;
		send_random(30);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		// Long receiver hold-off while commands keep coming.
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			send_random(30);
		join
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(25);
		wait_drained();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
